### rtl/core/fir32sp_pkg.sv
// ----------------------------------------------------------------------------
// fir32sp_pkg
// Types, constants and the tap weight function shared by the FIR sample
// pipeline and its sub-blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package fir32sp_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned HIST_W    = SAMPLE_W + 1;
  localparam int unsigned HIST_AW   = 5;
  localparam int unsigned TAP_W     = 5;
  localparam int unsigned ACC_W     = 20;
  localparam int unsigned FILT_W    = 12;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OUT_SHIFT = 8;

  localparam logic [HIST_W-1:0] SAMPLE_OFFSET = 11'd512;
  localparam logic [FILT_W-1:0] FILT_OFFSET   = 12'd512;
  localparam logic [HIST_AW-1:0] LAST_TAP     = 5'd31;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
    logic [WORD_W-1:0]   seq_num;
    logic [WORD_W-1:0]   issued_time;
    logic [WORD_W-1:0]   now_time;
  } in_item_t;

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic [WORD_W-1:0]        latency;
    logic [WORD_W-1:0]        latency_max;
    logic [WORD_W-1:0]        running_checksum;
    logic [WORD_W-1:0]        frames_done;
  } out_item_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [HIST_W-1:0]  wr_data;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
    logic [HIST_AW-1:0] rd_tap;
    logic               acc_clr;
  } mac_ctl_t;

  // Control from the sequencer to the statistics unit.
  typedef struct packed {
    logic update;
    logic clear;
  } stats_ctl_t;

  // Triangular weights: 1..16 on the first half, 16..1 on the second.
  function automatic logic [TAP_W-1:0] tap_weight(input logic [HIST_AW-1:0] tap);
    logic [TAP_W:0] w;
    begin
      if (tap[HIST_AW-1] == 1'b0) begin
        w = {1'b0, tap} + 6'd1;
      end else begin
        w = 6'd32 - {1'b0, tap};
      end
      return w[TAP_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/fir32sp_mac.sv
// ----------------------------------------------------------------------------
// fir32sp_mac
// Sample history store and the shared multiply-accumulate unit. One history
// entry is read per cycle; the registered read data is weighted and summed.
// ----------------------------------------------------------------------------
`default_nettype none

module fir32sp_mac (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire fir32sp_pkg::mac_ctl_t                    ctl,
  output logic signed [fir32sp_pkg::ACC_W-1:0]          acc
);

  localparam int unsigned DEPTH = 2 ** fir32sp_pkg::HIST_AW;
  localparam int unsigned PROD_W = fir32sp_pkg::HIST_W + fir32sp_pkg::TAP_W + 1;

  logic [fir32sp_pkg::HIST_W-1:0]  hist_mem [DEPTH];
  logic [DEPTH-1:0]                hist_vld_r;
  logic [DEPTH-1:0]                hist_vld_nxt;

  logic [fir32sp_pkg::HIST_W-1:0]  rd_data_r;
  logic                            rd_hit_r;
  logic                            rd_vld_r;
  logic                            rd_vld_nxt;
  logic [fir32sp_pkg::HIST_AW-1:0] rd_tap_r;

  logic signed [fir32sp_pkg::ACC_W-1:0] acc_r;
  logic signed [fir32sp_pkg::ACC_W-1:0] acc_nxt;

  logic signed [fir32sp_pkg::HIST_W-1:0] tap_data;
  logic signed [PROD_W-1:0]              prod;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      hist_mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= hist_mem[ctl.rd_addr];
      rd_hit_r  <= hist_vld_r[ctl.rd_addr];
      rd_tap_r  <= ctl.rd_tap;
    end
  end

  always_comb begin
    hist_vld_nxt = hist_vld_r;
    if (ctl.wr_en) begin
      hist_vld_nxt[ctl.wr_addr] = 1'b1;
    end
  end

  assign rd_vld_nxt = ctl.rd_en;

  assign tap_data = rd_hit_r ? $signed(rd_data_r) : '0;
  assign prod     = tap_data * $signed({1'b0, fir32sp_pkg::tap_weight(rd_tap_r)});

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (rd_vld_r) begin
      acc_nxt = acc_r + {{(fir32sp_pkg::ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      acc_r      <= '0;
    end else begin
      hist_vld_r <= hist_vld_nxt;
      rd_vld_r   <= rd_vld_nxt;
      acc_r      <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

### rtl/core/fir32sp_stats.sv
// ----------------------------------------------------------------------------
// fir32sp_stats
// Latency, peak latency, shift-xor checksum and frame count. Presents the
// values that the current request leaves, for loading into the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fir32sp_stats (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire fir32sp_pkg::stats_ctl_t                 ctl,
  input  wire logic signed [fir32sp_pkg::ACC_W-1:0]    acc,
  input  wire logic [fir32sp_pkg::WORD_W-1:0]          seq_num,
  input  wire logic [fir32sp_pkg::WORD_W-1:0]          issued_time,
  input  wire logic [fir32sp_pkg::WORD_W-1:0]          now_time,
  output logic [fir32sp_pkg::WORD_W-1:0]               latency,
  output logic [fir32sp_pkg::WORD_W-1:0]               peak_nxt_o,
  output logic [fir32sp_pkg::WORD_W-1:0]               checksum_nxt_o,
  output logic [fir32sp_pkg::WORD_W-1:0]               frames_nxt_o
);

  localparam int unsigned W = fir32sp_pkg::WORD_W;

  logic [W-1:0] peak_r,     peak_nxt;
  logic [W-1:0] checksum_r, checksum_nxt;
  logic [W-1:0] frames_r,   frames_nxt;
  logic [W-1:0] acc_ext;

  assign latency = now_time - issued_time;
  assign acc_ext = {{(W - fir32sp_pkg::ACC_W){acc[fir32sp_pkg::ACC_W-1]}}, acc};

  always_comb begin
    peak_nxt     = peak_r;
    checksum_nxt = checksum_r;
    frames_nxt   = frames_r;
    if (ctl.clear) begin
      peak_nxt     = '0;
      checksum_nxt = '0;
      frames_nxt   = '0;
    end else if (ctl.update) begin
      if (latency > peak_r) begin
        peak_nxt = latency;
      end
      checksum_nxt = (checksum_r << 5) ^ (checksum_r >> 2) ^ acc_ext ^ seq_num;
      frames_nxt   = frames_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r     <= '0;
      checksum_r <= '0;
      frames_r   <= '0;
    end else begin
      peak_r     <= peak_nxt;
      checksum_r <= checksum_nxt;
      frames_r   <= frames_nxt;
    end
  end

  assign peak_nxt_o     = peak_nxt;
  assign checksum_nxt_o = checksum_nxt;
  assign frames_nxt_o   = frames_nxt;

endmodule

`default_nettype wire

### rtl/core/fir32_sample_pipeline.sv
// ----------------------------------------------------------------------------
// fir32_sample_pipeline
// 32-tap triangular FIR filter with latency and checksum statistics.
// ----------------------------------------------------------------------------
// A sample request is written into the 32-entry history and then filtered by
// a single multiply-accumulate unit that reads one history entry per cycle,
// so the block takes no new request until it is back in idle: it writes the
// sample, runs the 32 taps, drains the read pipeline, forms the result and
// then returns to idle. A clear request goes straight from idle to forming
// its result. The result is held in an output register until it is taken; a
// finished request waits in its last step while that register is still full.
`default_nettype none

module fir32_sample_pipeline (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire fir32sp_pkg::in_item_t  in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output fir32sp_pkg::out_item_t      out_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRITE = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  fir32sp_pkg::in_item_t  item_r;
  fir32sp_pkg::out_item_t out_data_r;
  fir32sp_pkg::out_item_t out_data_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [fir32sp_pkg::HIST_AW-1:0] tap_r, tap_nxt;

  fir32sp_pkg::mac_ctl_t   mac_ctl;
  fir32sp_pkg::stats_ctl_t stats_ctl;

  logic signed [fir32sp_pkg::ACC_W-1:0] acc;
  logic signed [fir32sp_pkg::ACC_W-1:0] acc_rnd;
  logic [fir32sp_pkg::WORD_W-1:0]       latency;
  logic [fir32sp_pkg::WORD_W-1:0]       peak_nxt;
  logic [fir32sp_pkg::WORD_W-1:0]       checksum_nxt;
  logic [fir32sp_pkg::WORD_W-1:0]       frames_nxt;
  logic [fir32sp_pkg::FILT_W-1:0]       filt;
  logic [fir32sp_pkg::HIST_AW-1:0]      slot;
  logic                                 in_acc;
  logic                                 finish;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign slot     = item_r.seq_num[fir32sp_pkg::HIST_AW-1:0];
  assign finish   = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.op == fir32sp_pkg::OP_CLEAR) ? ST_DONE : ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_nxt = ST_RUN;
        tap_nxt   = '0;
      end
      ST_RUN: begin
        tap_nxt = tap_r + 5'd1;
        if (tap_r == fir32sp_pkg::LAST_TAP) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mac_ctl         = '0;
    mac_ctl.wr_en   = (state_r == ST_WRITE);
    mac_ctl.wr_addr = slot;
    mac_ctl.wr_data = {1'b0, item_r.sample} - fir32sp_pkg::SAMPLE_OFFSET;
    mac_ctl.rd_en   = (state_r == ST_RUN);
    mac_ctl.rd_addr = slot - tap_r;
    mac_ctl.rd_tap  = tap_r;
    mac_ctl.acc_clr = in_acc;
  end

  always_comb begin
    stats_ctl.clear  = finish && (item_r.op == fir32sp_pkg::OP_CLEAR);
    stats_ctl.update = finish && (item_r.op == fir32sp_pkg::OP_SAMPLE);
  end

  fir32sp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .acc   (acc)
  );

  fir32sp_stats u_stats (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (stats_ctl),
    .acc            (acc),
    .seq_num        (item_r.seq_num),
    .issued_time    (item_r.issued_time),
    .now_time       (item_r.now_time),
    .latency        (latency),
    .peak_nxt_o     (peak_nxt),
    .checksum_nxt_o (checksum_nxt),
    .frames_nxt_o   (frames_nxt)
  );

  // Division by 256 rounds toward zero, so negative sums are biased first.
  assign acc_rnd = acc + (acc[fir32sp_pkg::ACC_W-1] ? 20'sd255 : 20'sd0);
  assign filt    = acc_rnd[fir32sp_pkg::OUT_SHIFT +: fir32sp_pkg::FILT_W]
                   + fir32sp_pkg::FILT_OFFSET;

  always_comb begin
    out_data_nxt                  = out_data_r;
    out_valid_nxt                 = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.latency_max      = peak_nxt;
      out_data_nxt.running_checksum = checksum_nxt;
      out_data_nxt.frames_done      = frames_nxt;
      if (item_r.op == fir32sp_pkg::OP_CLEAR) begin
        out_data_nxt.filtered = '0;
        out_data_nxt.latency  = '0;
      end else begin
        out_data_nxt.filtered = $signed(filt);
        out_data_nxt.latency  = latency;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
    tap_r      <= tap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
